### hdl/zsrle_pkg.sv
// ----------------------------------------------------------------------------
// zsrle_pkg
// Types and constants shared by the zero-suppression run-length codec.
// ----------------------------------------------------------------------------
package zsrle_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int RUN_W          = 13;
    localparam int ROW_W          = 10;
    localparam int POS_W          = 12;
    localparam int IDX_W          = 22;
    localparam int LEN_W          = 13;
    localparam int ROWS_W         = 11;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;

    localparam int MAX_ROW_LENGTH = 4096;
    localparam int MAX_ROWS       = 1024;

    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [0:0] {
        MODE_COMPRESS = 1'b0,
        MODE_EXPAND   = 1'b1
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE        = 2'd0,
        CFG_THRESHOLD   = 2'd1,
        CFG_ROW_LENGTH  = 2'd2,
        CFG_ROWS_IN_USE = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_RUN,
        OP_VALUE,
        OP_RUN_VALUE,
        OP_WRITE,
        OP_OVERFLOW
    } t_op;

    typedef struct packed {
        t_op                        op;
        logic signed [SAMPLE_W-1:0] value;
        logic [RUN_W-1:0]           run_cnt;
        logic [ROW_W-1:0]           row;
        logic [POS_W-1:0]           run_pos;
        logic [POS_W-1:0]           val_pos;
        logic                       first;
        logic [IDX_W-1:0]           index;
    } t_entry;

    typedef struct packed {
        logic                       is_run_word;
        logic signed [SAMPLE_W-1:0] out_value;
        logic [RUN_W-1:0]           run_count;
        logic [ROW_W-1:0]           row_number;
        logic [POS_W-1:0]           position_in_row;
        logic                       first_of_row;
        logic [IDX_W-1:0]           stream_index;
        logic                       last;
        logic                       overflow_error;
    } t_word;

endpackage

### hdl/zsrle_if.sv
// ----------------------------------------------------------------------------
// zsrle channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface zsrle_in_if import zsrle_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       word_is_run;
    logic [RUN_W-1:0]           word_run_count;

    modport source (output valid, sample, word_is_run, word_run_count, input ready);
    modport sink   (input valid, sample, word_is_run, word_run_count, output ready);
endinterface

interface zsrle_out_if import zsrle_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       is_run_word;
    logic signed [SAMPLE_W-1:0] out_value;
    logic [RUN_W-1:0]           run_count;
    logic [ROW_W-1:0]           row_number;
    logic [POS_W-1:0]           position_in_row;
    logic                       first_of_row;
    logic [IDX_W-1:0]           stream_index;
    logic                       last;
    logic                       overflow_error;

    modport source (output valid, is_run_word, out_value, run_count, row_number,
                    position_in_row, first_of_row, stream_index, last,
                    overflow_error, input ready);
    modport sink   (input valid, is_run_word, out_value, run_count, row_number,
                    position_in_row, first_of_row, stream_index, last,
                    overflow_error, output ready);
endinterface

interface zsrle_cfg_if import zsrle_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/zsrle_front.sv
// ----------------------------------------------------------------------------
// zsrle_front
// Accepts items, keeps row and run state, and classifies each item into a
// queue entry describing the words it causes.
// ----------------------------------------------------------------------------
module zsrle_front import zsrle_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    zsrle_in_if.sink  i_in,
    zsrle_cfg_if.sink i_cfg,
    input  logic   i_full,
    output logic   o_push,
    output t_entry o_entry
);

    t_mode                      r_mode;
    logic signed [SAMPLE_W-1:0] r_threshold;
    logic [LEN_W-1:0]           r_row_length;
    logic [ROWS_W-1:0]          r_rows_in_use;

    logic [LEN_W-1:0]           r_position, n_position;
    logic [ROW_W-1:0]           r_row, n_row;
    logic [RUN_W-1:0]           r_sup, n_sup;
    logic [IDX_W-1:0]           r_word_cnt, n_word_cnt;
    logic                       r_pending, n_pending;

    logic                       accept;
    logic                       cfg_we;
    logic                       mode_we;
    logic [LEN_W-1:0]           eff_len;
    logic [ROWS_W-1:0]          eff_rows;

    logic                       kept;
    logic [LEN_W-1:0]           pos_inc;
    logic [RUN_W-1:0]           sup_inc;
    logic                       row_end;
    logic                       row_wrap;
    logic [LEN_W-1:0]           kept_start;
    logic [LEN_W-1:0]           end_start;

    logic [LEN_W:0]             step;
    logic [LEN_W:0]             sum;
    logic                       hit;
    logic                       over;
    logic                       wr;

    t_entry                     entry;

    assign i_in.ready  = !i_full;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_in.valid && i_in.ready;
    assign cfg_we      = i_cfg.valid && i_cfg.ready;
    assign mode_we     = cfg_we && (t_cfg_reg'(i_cfg.index) == CFG_MODE);

    assign eff_len  = (r_row_length == '0) ? LEN_W'(1) :
                      (r_row_length > LEN_W'(MAX_ROW_LENGTH)) ? LEN_W'(MAX_ROW_LENGTH) :
                      r_row_length;
    assign eff_rows = (r_rows_in_use == '0) ? ROWS_W'(1) :
                      (r_rows_in_use > ROWS_W'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS) :
                      r_rows_in_use;

    assign kept       = i_in.sample > r_threshold;
    assign pos_inc    = r_position + LEN_W'(1);
    assign sup_inc    = (r_sup == '1) ? r_sup : r_sup + RUN_W'(1);
    assign row_end    = pos_inc >= eff_len;
    assign row_wrap   = ({1'b0, r_row} + ROWS_W'(1)) >= eff_rows;
    assign kept_start = (r_sup <= r_position) ? r_position - r_sup : '0;
    assign end_start  = (sup_inc <= pos_inc) ? pos_inc - sup_inc : '0;

    assign step = i_in.word_is_run ? {1'b0, i_in.word_run_count} : (LEN_W + 1)'(1);
    assign sum  = {1'b0, r_position} + step;
    assign hit  = sum == {1'b0, eff_len};
    assign over = sum > {1'b0, eff_len};
    assign wr   = !i_in.word_is_run && (r_position < eff_len);

    always_comb begin
        n_position = r_position;
        n_row      = r_row;
        n_sup      = r_sup;
        n_word_cnt = r_word_cnt;
        n_pending  = r_pending;

        entry.op      = OP_NONE;
        entry.value   = i_in.sample;
        entry.run_cnt = '0;
        entry.row     = r_row;
        entry.run_pos = '0;
        entry.val_pos = r_position[POS_W-1:0];
        entry.first   = r_pending;
        entry.index   = r_word_cnt;

        if (accept) begin
            if (r_mode == MODE_COMPRESS) begin
                if (kept) begin
                    entry.op      = (r_sup != '0) ? OP_RUN_VALUE : OP_VALUE;
                    entry.run_cnt = r_sup;
                    entry.run_pos = kept_start[POS_W-1:0];
                    n_word_cnt    = r_word_cnt + ((r_sup != '0) ? IDX_W'(2) : IDX_W'(1));
                    n_pending     = 1'b0;
                    n_sup         = '0;
                end else begin
                    n_sup = sup_inc;
                    if (row_end) begin
                        entry.op      = OP_RUN;
                        entry.run_cnt = sup_inc;
                        entry.run_pos = end_start[POS_W-1:0];
                        n_word_cnt    = r_word_cnt + IDX_W'(1);
                        n_pending     = 1'b0;
                    end
                end
                if (row_end) begin
                    n_position = '0;
                    n_sup      = '0;
                    n_pending  = 1'b1;
                    if (row_wrap) begin
                        n_row      = '0;
                        n_word_cnt = '0;
                    end else begin
                        n_row = r_row + ROW_W'(1);
                    end
                end else begin
                    n_position = pos_inc;
                end
            end else begin
                entry.first = 1'b0;
                entry.index = '0;
                if (over) begin
                    entry.op      = OP_OVERFLOW;
                    entry.run_cnt = i_in.word_run_count;
                    n_position    = '0;
                    n_row         = '0;
                    n_sup         = '0;
                    n_word_cnt    = '0;
                    n_pending     = 1'b1;
                end else begin
                    if (wr) begin
                        entry.op = OP_WRITE;
                    end
                    if (hit) begin
                        n_position = '0;
                        n_row      = row_wrap ? '0 : r_row + ROW_W'(1);
                    end else begin
                        n_position = sum[LEN_W-1:0];
                    end
                end
            end
        end

        if (mode_we) begin
            n_position = '0;
            n_row      = '0;
            n_sup      = '0;
            n_word_cnt = '0;
            n_pending  = 1'b1;
        end
    end

    assign o_push  = accept && (entry.op != OP_NONE);
    assign o_entry = entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_COMPRESS;
            r_threshold   <= '0;
            r_row_length  <= LEN_W'(MAX_ROW_LENGTH);
            r_rows_in_use <= ROWS_W'(MAX_ROWS);
        end else if (cfg_we) begin
            case (t_cfg_reg'(i_cfg.index))
                CFG_MODE:        r_mode        <= t_mode'(i_cfg.data[0]);
                CFG_THRESHOLD:   r_threshold   <= i_cfg.data[SAMPLE_W-1:0];
                CFG_ROW_LENGTH:  r_row_length  <= i_cfg.data[LEN_W-1:0];
                CFG_ROWS_IN_USE: r_rows_in_use <= i_cfg.data[ROWS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_row      <= '0;
            r_sup      <= '0;
            r_word_cnt <= '0;
            r_pending  <= 1'b1;
        end else begin
            r_position <= n_position;
            r_row      <= n_row;
            r_sup      <= n_sup;
            r_word_cnt <= n_word_cnt;
            r_pending  <= n_pending;
        end
    end

    a_position_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_position < LEN_W'(MAX_ROW_LENGTH))
        else $error("row position left its range");

endmodule

### hdl/zsrle_queue.sv
// ----------------------------------------------------------------------------
// zsrle_queue
// Short FIFO of classified entries between the front and the back.
// ----------------------------------------------------------------------------
module zsrle_queue import zsrle_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_head,
    input  logic   i_pop
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    assign o_full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

### hdl/zsrle_back.sv
// ----------------------------------------------------------------------------
// zsrle_back
// Turns queue entries into result words, one per cycle while o_out.ready is
// high, through an output register.
// ----------------------------------------------------------------------------
module zsrle_back import zsrle_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_entry i_head,
    output logic   o_pop,
    zsrle_out_if.source o_out
);

    logic  r_valid;
    logic  r_phase, n_phase;
    t_word r_word;
    t_word word;
    logic  two;
    logic  load;

    assign two   = i_head.op == OP_RUN_VALUE;
    assign load  = i_valid && (!r_valid || o_out.ready);
    assign o_pop = load && (!two || r_phase);

    always_comb begin
        n_phase = r_phase;
        if (load) begin
            n_phase = two && !r_phase;
        end
    end

    always_comb begin
        word                 = '0;
        word.row_number      = i_head.row;
        word.last            = 1'b1;
        case (i_head.op)
            OP_RUN: begin
                word.is_run_word     = 1'b1;
                word.run_count       = i_head.run_cnt;
                word.position_in_row = i_head.run_pos;
                word.first_of_row    = i_head.first;
                word.stream_index    = i_head.index;
            end
            OP_VALUE, OP_WRITE: begin
                word.out_value       = i_head.value;
                word.position_in_row = i_head.val_pos;
                word.first_of_row    = i_head.first;
                word.stream_index    = i_head.index;
            end
            OP_RUN_VALUE: begin
                if (!r_phase) begin
                    word.is_run_word     = 1'b1;
                    word.run_count       = i_head.run_cnt;
                    word.position_in_row = i_head.run_pos;
                    word.first_of_row    = i_head.first;
                    word.stream_index    = i_head.index;
                    word.last            = 1'b0;
                end else begin
                    word.out_value       = i_head.value;
                    word.position_in_row = i_head.val_pos;
                    word.stream_index    = i_head.index + IDX_W'(1);
                end
            end
            OP_OVERFLOW: begin
                word.is_run_word    = 1'b1;
                word.run_count      = i_head.run_cnt;
                word.overflow_error = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= word;
        end
    end

    assign o_out.valid           = r_valid;
    assign o_out.is_run_word     = r_word.is_run_word;
    assign o_out.out_value       = r_word.out_value;
    assign o_out.run_count       = r_word.run_count;
    assign o_out.row_number      = r_word.row_number;
    assign o_out.position_in_row = r_word.position_in_row;
    assign o_out.first_of_row    = r_word.first_of_row;
    assign o_out.stream_index    = r_word.stream_index;
    assign o_out.last            = r_word.last;
    assign o_out.overflow_error  = r_word.overflow_error;

    a_phase_on_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (i_valid && i_head.op == OP_RUN_VALUE))
        else $error("second word pending without a run and value entry");

    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last)
        |=> (o_out.valid && o_out.last && !o_out.is_run_word))
        else $error("value word did not follow its run word");

endmodule

### hdl/zero_suppression_rle_codec_top.sv
// ----------------------------------------------------------------------------
// zero_suppression_rle_codec_top
// Zero-suppression run-length codec for detector rows, compress and expand.
// ----------------------------------------------------------------------------
// Channels: i_in takes one item per handshake (raw sample in compress mode,
// compressed word in expand mode); o_out gives result items, with last set
// on the final result of each input item; i_cfg writes mode, threshold,
// row_length and rows_in_use by index and is always ready. Write config
// only while the block is idle; a mode write restarts the stream.
// Path: the queue is written at the edge that takes the item, and the output
// register loads from the queue head when it is free, so a result is offered
// from the output register after its entry has passed through the queue.
// Throughput: one item per cycle while each item causes at most one result
// and o_out.ready stays high. The output register moves one result per
// cycle, so a run word and value word from one item occupy it in turn; a
// four-entry queue between classification and word formatting absorbs them.
// Items that cause no result never enter the queue.
// Reset: synchronous, active low; registers return to their defaults,
// position, row, run count and stream index clear, and the next word is
// flagged first of row.
// Stall: when o_out.ready is low the output holds, the queue fills, and
// i_in.ready drops once four entries are waiting.
// ----------------------------------------------------------------------------
module zero_suppression_rle_codec_top import zsrle_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    zsrle_in_if.sink    i_in,
    zsrle_cfg_if.sink   i_cfg,
    zsrle_out_if.source o_out
);

    logic   push;
    logic   full;
    logic   head_valid;
    logic   pop;
    t_entry push_entry;
    t_entry head_entry;

    zsrle_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    zsrle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .o_valid (head_valid),
        .o_head  (head_entry),
        .i_pop   (pop)
    );

    zsrle_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .i_head  (head_entry),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

### tb/zero_suppression_rle_codec_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zero_suppression_rle_codec_top_tb
// Drives raw samples and compressed words through the codec in both modes,
// writes every register across small, clamped and extreme settings, and
// checks each result item against a cycle-free prediction of the codec.
// Both channels idle at random; one long output hold fills the block.
// ----------------------------------------------------------------------------
module zero_suppression_rle_codec_top_tb;
    import zsrle_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 120;
    localparam int RANDOM_ITEMS  = 620;
    localparam int LARGE_ITEMS   = 256;
    localparam int CYCLE_LIMIT   = 2000000;

    class zsrle_scoreboard;
        t_word                      pending_words[$];
        t_word                      step_words[$];
        int                         errors;
        t_mode                      mode;
        logic signed [SAMPLE_W-1:0] threshold;
        logic [LEN_W-1:0]           row_length;
        logic [ROWS_W-1:0]          rows_in_use;
        int unsigned                position;
        int unsigned                current_row;
        int unsigned                zero_run;
        logic [IDX_W-1:0]           word_index;
        logic                       row_pending;

        function new();
            errors      = 0;
            mode        = MODE_COMPRESS;
            threshold   = '0;
            row_length  = LEN_W'(MAX_ROW_LENGTH);
            rows_in_use = ROWS_W'(MAX_ROWS);
            restart_stream();
        endfunction

        function void restart_stream();
            position    = 0;
            current_row = 0;
            zero_run    = 0;
            word_index  = '0;
            row_pending = 1'b1;
        endfunction

        function int unsigned len_limit();
            if (row_length == 0) return 1;
            if (row_length > MAX_ROW_LENGTH) return MAX_ROW_LENGTH;
            return row_length;
        endfunction

        function int unsigned row_limit();
            if (rows_in_use == 0) return 1;
            if (rows_in_use > MAX_ROWS) return MAX_ROWS;
            return rows_in_use;
        endfunction

        function void note_config(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MODE: begin
                    mode = t_mode'(data[0]);
                    restart_stream();
                end
                CFG_THRESHOLD:   threshold   = data;
                CFG_ROW_LENGTH:  row_length  = data[LEN_W-1:0];
                CFG_ROWS_IN_USE: rows_in_use = data[ROWS_W-1:0];
                default: ;
            endcase
        endfunction

        function void add_word(logic run, logic signed [SAMPLE_W-1:0] val, int unsigned cnt,
                               int unsigned row, int unsigned pos, logic first,
                               logic [IDX_W-1:0] idx, logic err);
            t_word w;
            w.is_run_word     = run;
            w.out_value       = val;
            w.run_count       = cnt[RUN_W-1:0];
            w.row_number      = row[ROW_W-1:0];
            w.position_in_row = pos[POS_W-1:0];
            w.first_of_row    = first;
            w.stream_index    = idx;
            w.last            = 1'b0;
            w.overflow_error  = err;
            step_words.push_back(w);
        endfunction

        function void emit_stream_word(logic run, logic signed [SAMPLE_W-1:0] val,
                                       int unsigned cnt, int unsigned pos);
            add_word(run, val, cnt, current_row, pos, row_pending, word_index, 1'b0);
            row_pending = 1'b0;
            word_index  = word_index + 1'b1;
        endfunction

        function int unsigned run_start();
            return (zero_run <= position) ? position - zero_run : 0;
        endfunction

        function void compress_sample(logic signed [SAMPLE_W-1:0] smp);
            int unsigned rl;
            rl = len_limit();
            if (smp <= threshold) begin
                if (zero_run < 32'h1FFF) zero_run++;
                position++;
            end else begin
                if (zero_run > 0) begin
                    emit_stream_word(1'b1, '0, zero_run, run_start());
                    zero_run = 0;
                end
                emit_stream_word(1'b0, smp, 0, position);
                position++;
            end
            if (position >= rl) begin
                if (zero_run > 0) emit_stream_word(1'b1, '0, zero_run, run_start());
                zero_run    = 0;
                position    = 0;
                row_pending = 1'b1;
                current_row++;
                if (current_row >= row_limit()) begin
                    current_row = 0;
                    word_index  = '0;
                end
            end
        endfunction

        function void expand_word(logic signed [SAMPLE_W-1:0] smp, logic is_run,
                                  logic [RUN_W-1:0] cnt);
            int unsigned rl;
            rl = len_limit();
            if (is_run) begin
                position += cnt;
            end else begin
                if (position < rl) add_word(1'b0, smp, 0, current_row, position, 1'b0, '0, 1'b0);
                position++;
            end
            if (position == rl) begin
                position = 0;
                current_row++;
                if (current_row >= row_limit()) current_row = 0;
            end else if (position > rl) begin
                add_word(1'b1, '0, cnt, current_row, 0, 1'b0, '0, 1'b1);
                restart_stream();
            end
        endfunction

        function void note_item(logic signed [SAMPLE_W-1:0] smp, logic is_run,
                                logic [RUN_W-1:0] cnt);
            step_words.delete();
            if (mode == MODE_COMPRESS) compress_sample(smp);
            else expand_word(smp, is_run, cnt);
            if (step_words.size() > 0) step_words[step_words.size()-1].last = 1'b1;
            foreach (step_words[i]) pending_words.push_back(step_words[i]);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_word(t_word got);
            t_word want;
            if (pending_words.size() == 0) begin
                errors++;
                $display("%0t: result item with none expected: run=%0d value=%0d count=%0d",
                         $time, got.is_run_word, got.out_value, got.run_count);
                return;
            end
            want = pending_words.pop_front();
            compare_field("is_run_word", want.is_run_word, got.is_run_word);
            compare_field("out_value", want.out_value, got.out_value);
            compare_field("run_count", want.run_count, got.run_count);
            compare_field("row_number", want.row_number, got.row_number);
            compare_field("position_in_row", want.position_in_row, got.position_in_row);
            compare_field("first_of_row", want.first_of_row, got.first_of_row);
            compare_field("stream_index", want.stream_index, got.stream_index);
            compare_field("last", want.last, got.last);
            compare_field("overflow_error", want.overflow_error, got.overflow_error);
        endfunction
    endclass

    logic            i_clk;
    logic            i_rst_n;
    zsrle_scoreboard sb;
    t_word           seen_word;
    int unsigned     cycle_count = 0;
    bit              in_valid_high = 1'b0;
    bit              burst = 1'b0;
    bit              hold_req = 1'b0;
    bit              hold_active = 1'b0;
    int              random_items = 0;

    zsrle_in_if  in_if ();
    zsrle_cfg_if cfg_if ();
    zsrle_out_if out_if ();

    zero_suppression_rle_codec_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            seen_word.is_run_word     = out_if.is_run_word;
            seen_word.out_value       = out_if.out_value;
            seen_word.run_count       = out_if.run_count;
            seen_word.row_number      = out_if.row_number;
            seen_word.position_in_row = out_if.position_in_row;
            seen_word.first_of_row    = out_if.first_of_row;
            seen_word.stream_index    = out_if.stream_index;
            seen_word.last            = out_if.last;
            seen_word.overflow_error  = out_if.overflow_error;
            sb.check_word(seen_word);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver: random ready pattern, one long hold on request
    initial begin
        int gap;
        int burst_len;
        out_if.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req    = 1'b0;
                hold_active = 1'b1;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_active = 1'b0;
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    out_if.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            out_if.ready <= 1'b1;
            burst_len = $urandom_range(1, 40);
            repeat (burst_len) @(posedge i_clk);
        end
    end

    task automatic send_item(input logic signed [SAMPLE_W-1:0] smp, input logic is_run,
                             input logic [RUN_W-1:0] cnt);
        int gap;
        gap = burst ? 0 : pick_gap();
        if (gap > 0) begin
            if (in_valid_high) in_if.valid <= 1'b0;
            in_valid_high = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid          <= 1'b1;
        in_if.sample         <= smp;
        in_if.word_is_run    <= is_run;
        in_if.word_run_count <= cnt;
        in_valid_high = 1'b1;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.note_item(smp, is_run, cnt);
    endtask

    task automatic end_items();
        if (in_valid_high) in_if.valid <= 1'b0;
        in_valid_high = 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        sb.note_config(idx, data);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(
            input logic signed [SAMPLE_W-1:0] thr);
        int t;
        int r;
        int v;
        t = thr;
        r = $urandom_range(0, 99);
        if (r < 45) v = int'($urandom_range(0, t + 32768)) - 32768;
        else if (r < 90 && t < 32767) v = t + 1 + int'($urandom_range(0, 32766 - t));
        else v = int'($urandom_range(0, 65535)) - 32768;
        return SAMPLE_W'(v);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_threshold();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 16'h8000;
        if (r < 30) return 16'h7FFF;
        if (r < 70) return CFG_DATA_W'(int'($urandom_range(0, 16)) - 8);
        return CFG_DATA_W'($urandom);
    endfunction

    function automatic logic [LEN_W-1:0] pick_row_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return LEN_W'($urandom_range(1, 16));
        if (r < 80) return '0;
        if (r < 90) return LEN_W'($urandom_range(17, 300));
        if (r < 95) return LEN_W'(MAX_ROW_LENGTH);
        return LEN_W'($urandom_range(MAX_ROW_LENGTH + 1, 8191));
    endfunction

    function automatic logic [ROWS_W-1:0] pick_rows();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return ROWS_W'($urandom_range(0, 4));
        if (r < 80) return ROWS_W'($urandom_range(5, 20));
        return ROWS_W'($urandom_range(21, 2047));
    endfunction

    task automatic send_compress(input int n);
        for (int i = 0; i < n; i++)
            send_item(pick_sample(sb.threshold), 1'($urandom), RUN_W'($urandom));
    endtask

    // mostly rows that fill exactly, some overshoots and stray words
    task automatic send_expand(input int n);
        int rl;
        int pos;
        int c;
        for (int i = 0; i < n; i++) begin
            rl  = sb.len_limit();
            pos = sb.position;
            if ($urandom_range(0, 99) < 88 && pos < rl) begin
                if ($urandom_range(0, 1)) begin
                    send_item(SAMPLE_W'($urandom), 1'b0, RUN_W'($urandom));
                end else begin
                    if ($urandom_range(0, 1)) c = $urandom_range(1, (rl - pos < 3) ? rl - pos : 3);
                    else c = $urandom_range(1, rl - pos);
                    send_item(SAMPLE_W'($urandom), 1'b1, RUN_W'(c));
                end
            end else begin
                case ($urandom_range(0, 2))
                    0: send_item(SAMPLE_W'($urandom), 1'b1, RUN_W'($urandom));
                    1: send_item(SAMPLE_W'($urandom), 1'b1, RUN_W'((rl > pos ? rl - pos : 0) + 1));
                    default: send_item(SAMPLE_W'($urandom), 1'b0, RUN_W'($urandom));
                endcase
            end
        end
    endtask

    task automatic random_phase();
        logic [CFG_DATA_W-1:0] d;
        logic                  m;
        int                    n;
        m = 1'($urandom);
        if (t_mode'(m) != sb.mode || $urandom_range(0, 99) < 70) begin
            d    = CFG_DATA_W'($urandom);
            d[0] = m;
            write_reg(CFG_MODE, d);
        end
        if ($urandom_range(0, 99) < 80) write_reg(CFG_THRESHOLD, pick_threshold());
        if ($urandom_range(0, 99) < 85) begin
            d = CFG_DATA_W'($urandom);
            d[LEN_W-1:0] = pick_row_length();
            write_reg(CFG_ROW_LENGTH, d);
        end
        if ($urandom_range(0, 99) < 85) begin
            d = CFG_DATA_W'($urandom);
            d[ROWS_W-1:0] = pick_rows();
            write_reg(CFG_ROWS_IN_USE, d);
        end
        n = $urandom_range(30, 90);
        if (sb.mode == MODE_COMPRESS) send_compress(n);
        else send_expand(n);
        random_items += n;
        end_items();
        wait_idle();
    endtask

    initial begin
        sb                   = new();
        i_rst_n              = 1'b0;
        in_if.valid          = 1'b0;
        in_if.sample         = '0;
        in_if.word_is_run    = 1'b0;
        in_if.word_run_count = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = CFG_MODE;
        cfg_if.data          = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // compress: extremes, run before value, run at row end, block wrap
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_COMPRESS));
        write_reg(CFG_THRESHOLD, 16'h0000);
        write_reg(CFG_ROW_LENGTH, 16'd4);
        write_reg(CFG_ROWS_IN_USE, 16'd2);
        send_item(16'sh0000, 1'b0, '0);
        send_item(16'sh8000, 1'b0, '0);
        send_item(16'sh7FFF, 1'b0, '0);
        send_item(16'sh0001, 1'b0, '0);
        repeat (4) send_item(16'sh0000, 1'b0, '0);
        send_item(16'sh0005, 1'b0, '0);
        send_item(16'sh0000, 1'b0, '0);
        send_item(16'sh0000, 1'b0, '0);
        end_items();
        wait_idle();
        // shrink the row mid-row
        write_reg(CFG_ROW_LENGTH, 16'd2);
        send_item(16'sh0007, 1'b0, '0);
        end_items();
        wait_idle();
        write_reg(CFG_THRESHOLD, 16'h7FFF);
        write_reg(CFG_ROW_LENGTH, 16'd0);
        send_item(16'sh7FFF, 1'b0, '0);
        send_item(16'sh8000, 1'b0, '0);
        end_items();
        wait_idle();
        write_reg(CFG_THRESHOLD, 16'h8000);
        send_item(16'sh8000, 1'b0, '0);
        send_item(16'sh8001, 1'b0, '0);
        end_items();
        wait_idle();

        // expand: writes, runs to row end, empty run, overshoot
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_EXPAND));
        write_reg(CFG_ROW_LENGTH, 16'd4);
        write_reg(CFG_ROWS_IN_USE, 16'd0);
        send_item(16'sh0064, 1'b0, '0);
        send_item(16'sh0000, 1'b1, 13'd2);
        send_item(16'sh8000, 1'b0, '0);
        send_item(16'sh0000, 1'b1, 13'd4);
        send_item(16'sh0000, 1'b1, 13'd0);
        send_item(16'sh0000, 1'b1, 13'd5);
        send_item(16'sh7FFF, 1'b0, '0);
        end_items();
        wait_idle();
        // value word past a shrunk row end, then maximal run
        write_reg(CFG_ROW_LENGTH, 16'd1);
        send_item(16'sh1234, 1'b0, 13'h1FFF);
        send_item(16'sh0000, 1'b1, 13'h1FFF);
        end_items();
        wait_idle();

        // hold the output while the input keeps offering
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_COMPRESS));
        write_reg(CFG_THRESHOLD, 16'h8000);
        write_reg(CFG_ROW_LENGTH, 16'd16);
        write_reg(CFG_ROWS_IN_USE, 16'd4);
        hold_req = 1'b1;
        while (!hold_active) @(posedge i_clk);
        burst = 1'b1;
        send_compress(80);
        burst = 1'b0;
        end_items();
        wait_idle();

        // start a full-size row, all suppressed
        write_reg(CFG_THRESHOLD, 16'h7FFF);
        write_reg(CFG_ROW_LENGTH, 16'(MAX_ROW_LENGTH));
        write_reg(CFG_ROWS_IN_USE, 16'd2047);
        burst = 1'b1;
        send_compress(LARGE_ITEMS);
        burst = 1'b0;
        end_items();
        wait_idle();

        while (random_items < RANDOM_ITEMS) random_phase();

        end_items();
        wait_idle();
        if (sb.errors == 0 && sb.pending_words.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### zero_suppression_rle_codec_top.f
hdl/zsrle_pkg.sv
hdl/zsrle_if.sv
hdl/zsrle_front.sv
hdl/zsrle_queue.sv
hdl/zsrle_back.sv
hdl/zero_suppression_rle_codec_top.sv
tb/zero_suppression_rle_codec_top_tb.sv
